// ===== src/swcl_pkg.sv =====
// ----------------------------------------------------------------------------
// swcl_pkg: shared types and constants
// Request codes, log states, wave modes, register indexes and the serial
// arithmetic sequencer states used across the waveform and capture logger.
// ----------------------------------------------------------------------------
package swcl_pkg;

    typedef enum logic [1:0] {
        REQ_ARM    = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        LOG_READY   = 2'd0,
        LOG_RUNNING = 2'd1,
        LOG_FULL    = 2'd2
    } t_log;

    localparam logic [1:0] WAVE_ZERO   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_SINE   = 2'd2;
    localparam logic [1:0] WAVE_TRI    = 2'd3;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_AMP  = 3'd1;
    localparam logic [2:0] REG_OFS  = 3'd2;
    localparam logic [2:0] REG_FREQ = 3'd3;
    localparam logic [2:0] REG_DS   = 3'd4;

    localparam logic [31:0] Q30_ONE     = 32'd1073741824;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // Sequencer states. Multiplies run one bit per cycle, divides by small
    // constants one quotient bit per cycle.
    typedef enum logic [4:0] {
        S_IDLE,
        S_PHASE,     // time * frequency, bit serial
        S_PHASE_END,
        S_TH,        // f * half pi
        S_T2,        // th * th
        S_DIV,       // x / divisor, restoring
        S_HMUL,      // t2 * a
        S_HSUB,
        S_FMUL,      // th * a
        S_AMUL,      // |amp| * wave
        S_FINISH,
        S_WR_TIME,
        S_WR_D,
        S_WR_P,
        S_WR_C,
        S_RD,
        S_RD_WAIT,
        S_OUT
    } t_seq;

    typedef struct packed {
        logic [15:0] setpoint;
        logic [31:0] read_word;
        logic [1:0]  log_state;
        logic [8:0]  rows_logged;
        logic        full_event;
    } t_res;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] time_now;
        logic [15:0] drive_sample;
        logic [15:0] position_sample;
        logic [15:0] current_sample;
        logic [7:0]  read_row;
        logic [1:0]  read_col;
    } t_req_item;

endpackage

// ===== src/swcl_if.sv =====
// ----------------------------------------------------------------------------
// swcl_if: valid/ready channel
// Carries one payload of type T; a transaction completes when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface swcl_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/setpoint_waveform_and_capture_logger.sv =====
// ----------------------------------------------------------------------------
// setpoint_waveform_and_capture_logger: test-signal generator and capture log
// Generates zero, square, sine and triangle setpoints, records sampled rows and reads them back.
// ----------------------------------------------------------------------------
// Queries in square, triangle and sine mode run bit-serial 32-bit multiplies;
//   sine queries also run restoring divides by constants.
// Throughput: one transaction in flight; the next is accepted the cycle after
//   its result enters the output register, which holds it until taken.
// Reset: synchronous active low; the log store holds no reset and is not cleared.
module setpoint_waveform_and_capture_logger #(
    parameter int ROWS = 256,
    parameter int COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swcl_if.sink        i_req,
    swcl_if.source      o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swcl_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  r_mode;
    logic [15:0] r_amp;
    logic [15:0] r_ofs;
    logic [31:0] r_freq;
    logic [7:0]  r_ds;
    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= WAVE_SQUARE;
            r_amp  <= '0;
            r_ofs  <= '0;
            r_freq <= '0;
            r_ds   <= 8'd1;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_MODE: r_mode <= pwdata[1:0];
                REG_AMP:  r_amp  <= pwdata[15:0];
                REG_OFS:  r_ofs  <= pwdata[15:0];
                REG_FREQ: r_freq <= pwdata;
                REG_DS:   r_ds   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_MODE: prdata = {30'd0, r_mode};
            REG_AMP:  prdata = {16'd0, r_amp};
            REG_OFS:  prdata = {16'd0, r_ofs};
            REG_FREQ: prdata = r_freq;
            REG_DS:   prdata = {24'd0, r_ds};
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Log control state
    // ------------------------------------------------------------------
    t_log        r_phase, n_phase;
    logic [RW-1:0] r_rows, n_rows;
    logic [7:0]  r_skip, n_skip;
    logic [31:0] r_origin, n_origin;

    // Held transaction and sequencer; r_res is the working result, r_out
    // the output register presented on the result channel
    t_seq        r_st, n_st;
    t_req_item   r_in, n_in;
    t_res        r_res, n_res;
    t_res        r_out, n_out;
    logic        r_ovalid, n_ovalid;

    // Serial multiplier: r_acc += r_mcand when multiplier LSB set, shifting
    // the 64-bit product right one bit a cycle.
    logic [31:0] r_mcand, n_mcand;
    logic [31:0] r_mplier, n_mplier;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_cnt, n_cnt;

    // Sine working values
    logic [31:0] r_th, n_th;
    logic [31:0] r_t2, n_t2;
    logic [31:0] r_a, n_a;
    logic [1:0]  r_quad, n_quad;
    logic [1:0]  r_term, n_term;   // Horner step: 0 /72, 1 /42, 2 /20, 3 /6
    // Divider: restoring, one quotient bit a cycle
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    // Final stage: signed product magnitude and sign
    logic        r_neg, n_neg;
    logic [33:0] r_wave, n_wave;

    // Store
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;
    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [31:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    logic [31:0] w_rel;
    logic [AW-1:0] w_base;
    logic [7:0] w_div;
    logic [32:0] w_sum;
    logic [32:0] w_trial;
    logic [15:0] w_abs_amp;
    logic signed [18:0] w_sum19;
    logic [17:0] w_mag;

    assign w_rel  = r_in.time_now - r_origin;
    assign w_base = AW'(r_rows * COLS);

    always_comb begin
        unique case (r_term)
            2'd0: w_div = 8'd72;
            2'd1: w_div = 8'd42;
            2'd2: w_div = 8'd20;
            default: w_div = 8'd6;
        endcase
    end

    assign w_abs_amp = r_amp[15] ? 16'(-r_amp) : r_amp;

    always_comb begin
        n_phase  = r_phase;
        n_rows   = r_rows;
        n_skip   = r_skip;
        n_origin = r_origin;
        n_st     = r_st;
        n_in     = r_in;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_th     = r_th;
        n_t2     = r_t2;
        n_a      = r_a;
        n_quad   = r_quad;
        n_term   = r_term;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_neg    = r_neg;
        n_wave   = r_wave;
        w_we     = 1'b0;
        w_addr   = '0;
        w_wdata  = '0;
        w_sum    = '0;
        w_trial  = '0;
        w_sum19  = '0;
        w_mag    = '0;
        i_req.ready = (r_st == S_IDLE);

        // Drop the output register once taken; a new result may reload it
        if (r_ovalid && o_res.ready) n_ovalid = 1'b0;

        // One multiplier bit: add and shift right
        w_sum = {1'b0, r_acc} + (r_mplier[0] ? {1'b0, r_mcand} : 33'd0);

        unique case (r_st)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_in  = i_req.data;
                    n_res = '0;
                    unique case (t_req'(i_req.data.req_type))
                        REQ_ARM: begin
                            n_rows  = '0;
                            n_skip  = '0;
                            n_phase = LOG_RUNNING;
                            n_st    = S_OUT;
                        end
                        REQ_QUERY: begin
                            if (r_phase == LOG_RUNNING) begin
                                if (r_rows == '0) n_origin = i_req.data.time_now;
                                n_mcand = r_freq;
                                n_acc   = '0;
                                n_cnt   = '0;
                                n_st    = (r_mode == WAVE_ZERO) ? S_OUT : S_PHASE;
                                // sine uses time since origin
                                n_mplier = (r_mode == WAVE_SINE) ?
                                    i_req.data.time_now - ((r_rows == '0) ?
                                        i_req.data.time_now : r_origin)
                                    : i_req.data.time_now;
                            end else begin
                                n_st = S_OUT;
                            end
                        end
                        REQ_SAMPLE: begin
                            if (r_phase == LOG_RUNNING) begin
                                n_skip = r_skip + 8'd1;
                                if (n_skip == r_ds && 32'(r_rows) < 32'(ROWS)) begin
                                    n_skip = '0;
                                    n_st   = S_WR_TIME;
                                end else begin
                                    n_st = S_OUT;
                                end
                            end else begin
                                n_st = S_OUT;
                            end
                        end
                        default: n_st = S_RD;
                    endcase
                end
            end

            // Product time*freq; phase = bits 39..8. After 32 shifts the
            // upper word sits in r_acc and the lower word in r_mplier.
            S_PHASE: begin
                n_acc    = w_sum[32:1];
                n_mplier = {w_sum[0], r_mplier[31:1]};
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'd31) n_st = S_PHASE_END;
            end
            S_PHASE_END: begin
                // phase p held in r_th
                n_th = {r_acc[7:0], r_mplier[31:8]};
                unique case (r_mode)
                    WAVE_SQUARE: begin
                        n_neg  = n_th[31] ^ r_amp[15];
                        n_wave = {18'd0, w_abs_amp};
                        n_st   = S_FINISH;
                    end
                    WAVE_TRI: begin
                        n_wave = (n_th <= 32'h8000_0000) ? {1'b0, n_th, 1'b0}
                                 : {1'b0, (32'h0 - n_th), 1'b0};
                        n_neg   = r_amp[15];
                        // |amp| * w, w up to 2^32: multiply the 16-bit mag by w/2 serially
                        n_mcand = {16'd0, w_abs_amp};
                        n_mplier = n_wave[32:1];
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_st    = S_AMUL;
                    end
                    default: begin
                        n_quad  = n_th[31:30];
                        n_mcand = n_th[30] ? (Q30_ONE - {2'b00, n_th[29:0]})
                                           : {2'b00, n_th[29:0]};
                        n_mplier = HALF_PI_Q30;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_st    = S_TH;
                    end
                endcase
            end
            S_TH, S_T2, S_HMUL, S_FMUL: begin
                n_acc    = w_sum[32:1];
                n_mplier = {w_sum[0], r_mplier[31:1]};
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    // >>30 of the 64-bit product
                    n_cnt = '0;
                    n_acc = '0;
                    unique case (r_st)
                        S_TH: begin
                            n_th     = 32'({w_sum[32:1], w_sum[0], r_mplier[31:1]} >> 30);
                            n_mcand  = n_th;
                            n_mplier = n_th;
                            n_st     = S_T2;
                        end
                        S_T2: begin
                            n_t2   = 32'({w_sum[32:1], w_sum[0], r_mplier[31:1]} >> 30);
                            n_term = 2'd0;
                            n_rem  = '0;
                            n_quo  = n_t2;
                            n_st   = S_DIV;
                        end
                        S_HMUL: begin
                            n_rem = '0;
                            n_quo = 32'({w_sum[32:1], w_sum[0], r_mplier[31:1]} >> 30);
                            n_st  = S_DIV;
                        end
                        default: begin
                            n_a = 32'({w_sum[32:1], w_sum[0], r_mplier[31:1]} >> 30);
                            if (n_a > Q30_ONE) n_a = Q30_ONE;
                            n_neg   = r_quad[1] ^ r_amp[15];
                            n_mcand = {16'd0, w_abs_amp};
                            n_mplier = n_a;
                            n_st    = S_AMUL;
                        end
                    endcase
                end
            end
            // Restoring divide of r_quo by w_div, 32 steps
            S_DIV: begin
                w_trial = {r_rem, r_quo[31]} - {25'd0, w_div};
                if (!w_trial[32]) begin
                    n_rem = w_trial[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_quo[31]};
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_cnt = '0;
                    n_a   = Q30_ONE - n_quo;
                    n_st  = S_HSUB;
                end
            end
            S_HSUB: begin
                if (r_term == 2'd3) begin
                    n_mcand  = r_th;
                    n_mplier = r_a;
                    n_st     = S_FMUL;
                end else begin
                    n_term   = r_term + 2'd1;
                    n_mcand  = r_t2;
                    n_mplier = r_a;
                    n_st     = S_HMUL;
                end
                n_acc = '0;
                n_cnt = '0;
            end
            // |amp| * wave: product kept as hi word in r_acc, lo in r_mplier
            S_AMUL: begin
                n_acc    = w_sum[32:1];
                n_mplier = {w_sum[0], r_mplier[31:1]};
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    if (r_mode == WAVE_TRI) begin
                        // product of |amp| * w/2; >>31 with rounding
                        n_wave = 34'({w_sum[32:1], w_sum[0], r_mplier[31:1]}
                                 + 64'h4000_0000 >> 31);
                    end else begin
                        n_wave = 34'({w_sum[32:1], w_sum[0], r_mplier[31:1]}
                                 + 64'h2000_0000 >> 30);
                    end
                    n_st = S_FINISH;
                end
            end
            S_FINISH: begin
                w_mag   = r_wave[17:0];
                w_sum19 = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
                if (r_mode != WAVE_SQUARE)
                    w_sum19 = w_sum19 + 19'($signed(r_ofs));
                if (w_sum19 > 19'sd32767)       n_res.setpoint = 16'h7FFF;
                else if (w_sum19 < -19'sd32768) n_res.setpoint = 16'h8000;
                else                            n_res.setpoint = w_sum19[15:0];
                n_st = S_OUT;
            end
            S_WR_TIME: begin
                w_we = 1'b1; w_addr = w_base; w_wdata = w_rel;
                n_st = S_WR_D;
            end
            S_WR_D: begin
                w_we = 1'b1; w_addr = w_base + AW'(1);
                w_wdata = 32'($signed(r_in.drive_sample));
                n_st = S_WR_P;
            end
            S_WR_P: begin
                w_we = 1'b1; w_addr = w_base + AW'(2);
                w_wdata = 32'($signed(r_in.position_sample));
                n_st = (COLS > 3) ? S_WR_C : S_OUT;
                if (COLS <= 3) begin
                    n_rows = r_rows + RW'(1);
                    if (32'(n_rows) >= 32'(ROWS)) begin
                        n_phase = LOG_FULL; n_res.full_event = 1'b1;
                    end
                end
            end
            S_WR_C: begin
                w_we = 1'b1; w_addr = w_base + AW'(COLS - 1);
                w_wdata = 32'($signed(r_in.current_sample));
                n_rows = r_rows + RW'(1);
                if (32'(n_rows) >= 32'(ROWS)) begin
                    n_phase = LOG_FULL; n_res.full_event = 1'b1;
                end
                n_st = S_OUT;
            end
            S_RD: begin
                w_addr = AW'(32'(r_in.read_row) * COLS + 32'(r_in.read_col));
                n_st = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                if (32'(r_in.read_row) < 32'(ROWS) && 32'(r_in.read_col) < 32'(COLS))
                    n_res.read_word = r_rdata;
                n_st = S_OUT;
            end
            // Hold here while the previous result still waits to be taken
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_out             = r_res;
                    n_out.log_state   = n_phase;
                    n_out.rows_logged = 9'(n_rows);
                    n_ovalid = 1'b1;
                    n_st     = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= LOG_READY;
            r_rows   <= '0;
            r_skip   <= '0;
            r_origin <= '0;
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_rows   <= n_rows;
            r_skip   <= n_skip;
            r_origin <= n_origin;
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_res    <= n_res;
        r_out    <= n_out;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_th     <= n_th;
        r_t2     <= n_t2;
        r_a      <= n_a;
        r_quad   <= n_quad;
        r_term   <= n_term;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_neg    <= n_neg;
        r_wave   <= n_wave;
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // Hold the result until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> r_ovalid && $stable(r_out))
        else $error("result changed while stalled");
    // A finished transaction waits while the output register is occupied
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT && r_ovalid && !o_res.ready |=> r_st == S_OUT)
        else $error("result overwritten while pending");
    // Full only when the row count has reached the depth
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == LOG_FULL |-> 32'(r_rows) == 32'(ROWS))
        else $error("full with rows short");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: setpoint waveform generator and capture logger
// Drives request transactions from a pending queue, predicts every result
// with a behavioural copy of the waveform maths and the capture log, and
// compares each result transaction field by field in a clocked monitor.
// ----------------------------------------------------------------------------
module testbench;
    import swcl_pkg::*;

    localparam int N_ROWS = 256;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    swcl_if #(.T(t_req_item)) req_ch ();
    swcl_if #(.T(t_res))      res_ch ();

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    setpoint_waveform_and_capture_logger #(.ROWS(N_ROWS), .COLS(4)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow configuration and log state used for prediction
    logic [1:0]  sh_mode = WAVE_SQUARE;
    logic [15:0] sh_amp = '0;
    logic [15:0] sh_ofs = '0;
    logic [31:0] sh_freq = '0;
    logic [7:0]  sh_ds = 8'd1;
    logic [1:0]  sh_phase = LOG_READY;
    logic [8:0]  sh_rows = '0;
    logic [7:0]  sh_skip = '0;
    logic [31:0] sh_origin = '0;
    logic [31:0] sh_store [0:N_ROWS*4-1];
    int          rows_ever = 0;   // rows that hold data since reset

    t_req_item pending_reqs[$];
    t_res      expected_res[$];
    int        tx_idle = 0;
    int        rx_idle = 0;
    int        fail_count = 0;

    // ------------------------------------------------------------------
    // Waveform maths
    // ------------------------------------------------------------------
    function automatic logic [31:0] cycle_phase(input logic [31:0] t);
        logic [63:0] prod;
        prod = 64'(t) * 64'(sh_freq);
        return prod[39:8];
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint round_away(input longint v, input int sh);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Quarter-wave sine, Horner form of the odd series, Q2.30
    function automatic logic [63:0] quarter_sine(input logic [63:0] f);
        logic [63:0] th, t2, a;
        th = (f * 64'(HALF_PI_Q30)) >> 30;
        t2 = (th * th) >> 30;
        a = 64'(Q30_ONE) - t2 / 72;
        a = 64'(Q30_ONE) - ((t2 * a) >> 30) / 42;
        a = 64'(Q30_ONE) - ((t2 * a) >> 30) / 20;
        a = 64'(Q30_ONE) - ((t2 * a) >> 30) / 6;
        a = (th * a) >> 30;
        return (a > 64'(Q30_ONE)) ? 64'(Q30_ONE) : a;
    endfunction

    function automatic logic [15:0] wave_setpoint(input logic [31:0] t);
        longint amp, ofs, v;
        logic [31:0] p;
        logic [29:0] r;
        logic [63:0] f, w;
        amp = longint'($signed(sh_amp));
        ofs = longint'($signed(sh_ofs));
        v = 0;
        case (sh_mode)
            WAVE_SQUARE: begin
                p = cycle_phase(t);
                v = clamp16(p[31] ? -amp : amp);
            end
            WAVE_SINE: begin
                p = cycle_phase(t - sh_origin);
                r = p[29:0];
                f = p[30] ? (64'h4000_0000 - 64'(r)) : 64'(r);
                v = amp * longint'(quarter_sine(f));
                if (p[31]) v = -v;
                v = clamp16(round_away(v, 30) + ofs);
            end
            WAVE_TRI: begin
                p = cycle_phase(t);
                w = (p <= 32'h8000_0000) ? 64'(p) * 2 : (64'h1_0000_0000 - 64'(p)) * 2;
                v = amp * longint'(w);
                v = clamp16(round_away(v, 32) + ofs);
            end
            default: v = 0;
        endcase
        return v[15:0];
    endfunction

    // Advance the shadow log by one request and queue the result it causes
    task automatic predict_result(input t_req_item it);
        t_res r;
        int   base;
        r = '0;
        case (it.req_type)
            REQ_ARM: begin
                sh_rows  = '0;
                sh_skip  = '0;
                sh_phase = LOG_RUNNING;
            end
            REQ_QUERY: begin
                if (sh_phase == LOG_RUNNING) begin
                    if (sh_rows == 0) sh_origin = it.time_now;
                    r.setpoint = wave_setpoint(it.time_now);
                end
            end
            REQ_SAMPLE: begin
                if (sh_phase == LOG_RUNNING) begin
                    sh_skip = sh_skip + 8'd1;
                    if (sh_skip == sh_ds && sh_rows < N_ROWS) begin
                        base = int'(sh_rows) * 4;
                        sh_skip = '0;
                        sh_store[base]     = it.time_now - sh_origin;
                        sh_store[base + 1] = 32'($signed(it.drive_sample));
                        sh_store[base + 2] = 32'($signed(it.position_sample));
                        sh_store[base + 3] = 32'($signed(it.current_sample));
                        sh_rows = sh_rows + 9'd1;
                        if (int'(sh_rows) > rows_ever) rows_ever = int'(sh_rows);
                        if (sh_rows >= N_ROWS) begin
                            sh_phase = LOG_FULL;
                            r.full_event = 1'b1;
                        end
                    end
                end
            end
            default: begin
                r.read_word = sh_store[int'(it.read_row) * 4 + int'(it.read_col)];
            end
        endcase
        r.log_state   = sh_phase;
        r.rows_logged = sh_rows;
        expected_res.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driver: hold the current transaction until taken, then pull the next
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold
        end else begin
            if (req_ch.valid) predict_result(req_ch.data);
            if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_reqs.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random and check each result against the oldest
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= rx_idle);
            if (res_ch.valid && res_ch.ready) begin
                if (expected_res.size() == 0) begin
                    $display("%0t unexpected result %h", $realtime, res_ch.data);
                    fail_count++;
                end else begin
                    want = expected_res.pop_front();
                    if (res_ch.data.setpoint !== want.setpoint) begin
                        $display("%0t setpoint exp %h got %h", $realtime,
                                 want.setpoint, res_ch.data.setpoint);
                        fail_count++;
                    end
                    if (res_ch.data.read_word !== want.read_word) begin
                        $display("%0t read_word exp %h got %h", $realtime,
                                 want.read_word, res_ch.data.read_word);
                        fail_count++;
                    end
                    if (res_ch.data.log_state !== want.log_state) begin
                        $display("%0t log_state exp %h got %h", $realtime,
                                 want.log_state, res_ch.data.log_state);
                        fail_count++;
                    end
                    if (res_ch.data.rows_logged !== want.rows_logged) begin
                        $display("%0t rows_logged exp %h got %h", $realtime,
                                 want.rows_logged, res_ch.data.rows_logged);
                        fail_count++;
                    end
                    if (res_ch.data.full_event !== want.full_event) begin
                        $display("%0t full_event exp %h got %h", $realtime,
                                 want.full_event, res_ch.data.full_event);
                        fail_count++;
                    end
                end
            end
        end
    end

    // APB write: setup cycle, then access cycle; update the shadow copy
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE: sh_mode = val[1:0];
            REG_AMP:  sh_amp  = val[15:0];
            REG_OFS:  sh_ofs  = val[15:0];
            REG_FREQ: sh_freq = val;
            default:  sh_ds   = val[7:0];
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [15:0] amp,
                              input logic [15:0] ofs, input logic [31:0] freq,
                              input logic [7:0] ds);
        reg_write(REG_MODE, 32'(mode));
        reg_write(REG_AMP, 32'(amp));
        reg_write(REG_OFS, 32'(ofs));
        reg_write(REG_FREQ, freq);
        reg_write(REG_DS, 32'(ds));
    endtask

    // Drop back to idle: wait for every transaction and result, plus margin
    task automatic drain;
        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Build one request; reads only target rows that already hold data
    function automatic t_req_item make_req(input logic [1:0] kind);
        t_req_item it;
        it.req_type        = kind;
        it.time_now        = $urandom;
        it.drive_sample    = 16'($urandom);
        it.position_sample = 16'($urandom);
        it.current_sample  = 16'($urandom);
        it.read_col        = 2'($urandom);
        it.read_row        = (rows_ever > 0) ? 8'($urandom_range(rows_ever - 1)) : 8'd0;
        if (kind == REQ_READ && rows_ever == 0) it.req_type = REQ_QUERY;
        return it;
    endfunction

    task automatic push_kind(input logic [1:0] kind);
        pending_reqs.push_back(make_req(kind));
    endtask

    // Mostly arm-then-traffic sequences, with stray arms as noise
    task automatic random_phase(input int n);
        int k;
        push_kind(REQ_ARM);
        repeat (n) begin
            k = $urandom_range(99);
            if (k < 4)       push_kind(REQ_ARM);
            else if (k < 34) push_kind(REQ_QUERY);
            else if (k < 74) push_kind(REQ_SAMPLE);
            else             push_kind(REQ_READ);
        end
    endtask

    initial begin
        t_req_item it;
        logic [1:0] modes [4];
        modes = '{WAVE_ZERO, WAVE_SQUARE, WAVE_SINE, WAVE_TRI};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: traffic before arming, then reset-value square wave
        push_kind(REQ_QUERY);
        push_kind(REQ_SAMPLE);
        push_kind(REQ_ARM);
        push_kind(REQ_QUERY);
        repeat (2) push_kind(REQ_SAMPLE);
        drain();

        // Square with most negative amplitude saturates on the negative half
        set_config(WAVE_SQUARE, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 8'd1);
        it = make_req(REQ_QUERY); it.time_now = 32'h0000_0000; pending_reqs.push_back(it);
        it = make_req(REQ_QUERY); it.time_now = 32'hFFFF_FFFF; pending_reqs.push_back(it);
        for (int c = 0; c < 4; c++) begin
            it = make_req(REQ_READ); it.read_row = 8'd0; it.read_col = 2'(c);
            pending_reqs.push_back(it);
        end
        drain();

        // Sine and triangle at offset and amplitude extremes
        set_config(WAVE_SINE, 16'h7FFF, 16'h8000, 32'h0100_0000, 8'd2);
        push_kind(REQ_ARM);
        it = make_req(REQ_QUERY); it.time_now = 32'h0000_4000; pending_reqs.push_back(it);
        it = make_req(REQ_QUERY); it.time_now = 32'h0000_C000; pending_reqs.push_back(it);
        repeat (3) push_kind(REQ_SAMPLE);
        push_kind(REQ_QUERY);
        drain();
        set_config(WAVE_TRI, 16'h7FFF, 16'h7FFF, 32'h0100_0000, 8'd255);
        it = make_req(REQ_QUERY); it.time_now = 32'h0000_8000; pending_reqs.push_back(it);
        it = make_req(REQ_QUERY); it.time_now = 32'h0000_C000; pending_reqs.push_back(it);
        push_kind(REQ_READ);
        drain();

        // Fill the log: full event, traffic while full, reads over all rows
        set_config(WAVE_TRI, 16'h1234, 16'h0000, 32'h0000_0000, 8'd1);
        push_kind(REQ_ARM);
        repeat (N_ROWS + 3) push_kind(REQ_SAMPLE);
        push_kind(REQ_QUERY);
        drain();
        repeat (20) push_kind(REQ_READ);
        it = make_req(REQ_READ); it.read_row = 8'd255; it.read_col = 2'd3;
        pending_reqs.push_back(it);
        drain();

        // Random phases; advance the idling pattern every three phases
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin tx_idle = 26; rx_idle = 59; end
                1: begin tx_idle = 59; rx_idle = 26; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            set_config(modes[$urandom_range(3)], 16'($urandom), 16'($urandom),
                       (ph % 3 == 0) ? 32'hFFFF_FFFF : 32'($urandom),
                       (ph % 4 == 0) ? 8'd255 : 8'($urandom_range(1, 4)));
            random_phase(43);
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS setpoint_waveform_and_capture_logger");
        else
            $display("FAIL setpoint_waveform_and_capture_logger");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #40ms;
        $display("FAIL setpoint_waveform_and_capture_logger");
        $finish;
    end

endmodule

// ===== setpoint_waveform_and_capture_logger.f =====
src/swcl_pkg.sv
src/swcl_if.sv
src/setpoint_waveform_and_capture_logger.sv
sim/testbench.sv
